@@ hdl/ehvr_pkg.sv @@
// shared types and constants of the ethernet header parse and vlan retag unit
// byte offsets, opcodes, frame kinds, report and queue entry structs
// no dependencies
package ehvr_pkg;

	// per-frame opcodes, sampled on the first byte
	localparam logic [1:0] OP_PASS   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_STRIP  = 2'd2;

	// frame kind codes
	localparam logic [1:0] KIND_ETH2 = 2'd0;
	localparam logic [1:0] KIND_RAW  = 2'd1;
	localparam logic [1:0] KIND_SNAP = 2'd2;
	localparam logic [1:0] KIND_LLC  = 2'd3;

	localparam logic [15:0] TPID          = 16'h8100;
	localparam logic [7:0]  LEN_TYPE_MIN  = 8'h06;
	localparam logic [7:0]  RAW_MARK      = 8'hFF;
	localparam logic [7:0]  SNAP_MARK     = 8'hAA;
	localparam logic [7:0]  SNAP_CTRL     = 8'h03;
	localparam logic [3:0]  IHL_MASK      = 4'hF;

	// byte offsets in the input frame
	localparam logic [6:0] IDX_SRC_MAC    = 7'd6;
	localparam logic [6:0] IDX_TYPE       = 7'd12;
	localparam logic [6:0] IDX_TAG_END    = 7'd13;
	localparam logic [6:0] IDX_IHL        = 7'd14;
	localparam logic [6:0] IDX_STRIP_END  = 7'd17;
	localparam logic [6:0] IDX_PROTO      = 7'd23;
	localparam logic [6:0] IDX_SRC_IP     = 7'd26;
	localparam logic [6:0] IDX_DST_IP     = 7'd30;
	localparam logic [6:0] IDX_MAX        = 7'd127;

	// bytes that may precede the current byte in one queue entry
	localparam int HOLD_MAX = 5;
	localparam int CNT_W    = $clog2(HOLD_MAX + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int IN_TDATA_W   = 24;
	localparam int OUT_FIELDS_W = 236;
	localparam int OUT_TDATA_W  = 240;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] ethertype;
		logic [7:0]  b14;
		logic [7:0]  b15;
		logic [7:0]  b16;
		logic [7:0]  ip_protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] l4_ports;
	} hdr_t;

	typedef struct packed {
		logic        tagged_res;
		logic [11:0] vlan_id;
		logic [1:0]  frame_kind;
		logic [15:0] ethertype;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [7:0]  ip_protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] l4_ports;
	} rep_t;

	// one queue entry: pre_cnt prefix bytes, then data
	typedef struct packed {
		logic [HOLD_MAX-1:0][7:0] pre;
		logic [CNT_W-1:0]         pre_cnt;
		logic [7:0]               data;
		logic                     last;
		rep_t                     rep;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

@@ hdl/ehvr_front.sv @@
// front end: accepts input words, captures header fields, decides insert or strip
// and pushes one queue entry per word that produces output
// depends on ehvr_pkg
module ehvr_front import ehvr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // in_byte[7:0], new_tag[23:8]
	input  logic [1:0]            s_tuser,   // opcode[1:0]
	input  logic                  s_tlast,
	input  logic                  q_full,
	output push_t                 push
);

	logic [6:0]               idx_q;
	logic [1:0]               act_q;
	logic [15:0]              tag_q;
	logic [HOLD_MAX-1:0][7:0] held_q;
	hdr_t                     hdr_q;

	logic        accept;
	logic        first;
	logic [7:0]  in_b;
	logic [15:0] in_tag;
	logic [1:0]  op_in;
	logic [1:0]  act;
	logic        in_strip_win;
	logic        hold_now;
	logic [3:0]  ihl;
	logic [6:0]  l4_base;
	hdr_t        hdr_n;
	rep_t        rep_n;
	entry_t      ent;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign first    = (idx_q == '0);
	assign in_b     = s_tdata[7:0];
	assign in_tag   = s_tdata[23:8];
	assign op_in    = (s_tuser == OP_INSERT || s_tuser == OP_STRIP) ? s_tuser : OP_PASS;
	assign act      = first ? op_in : act_q;

	assign in_strip_win = (idx_q >= IDX_TYPE) && (idx_q < IDX_STRIP_END);
	assign hold_now = !s_tlast && ((act == OP_INSERT && idx_q == IDX_TYPE) ||
		(act == OP_STRIP && in_strip_win));

	// header capture including the current byte
	always_comb begin
		hdr_n = first ? '0 : hdr_q;
		for (int i = 0; i < 6; i++) begin
			if (idx_q == 7'(i)) hdr_n.dst_mac[8*(5-i) +: 8] = in_b;
			if (idx_q == IDX_SRC_MAC + 7'(i)) hdr_n.src_mac[8*(5-i) +: 8] = in_b;
		end
		if (idx_q == IDX_TYPE) hdr_n.ethertype[15:8] = in_b;
		if (idx_q == IDX_TAG_END) hdr_n.ethertype[7:0] = in_b;
		if (idx_q == IDX_IHL) hdr_n.b14 = in_b;
		if (idx_q == IDX_IHL + 7'd1) hdr_n.b15 = in_b;
		if (idx_q == IDX_IHL + 7'd2) hdr_n.b16 = in_b;
		if (idx_q == IDX_PROTO) hdr_n.ip_protocol = in_b;
		for (int i = 0; i < 4; i++) begin
			if (idx_q == IDX_SRC_IP + 7'(i)) hdr_n.src_ip[8*(3-i) +: 8] = in_b;
			if (idx_q == IDX_DST_IP + 7'(i)) hdr_n.dst_ip[8*(3-i) +: 8] = in_b;
		end
		ihl     = hdr_n.b14[3:0] & IHL_MASK;
		l4_base = IDX_IHL + {1'b0, ihl, 2'b00};
		if (idx_q >= IDX_IHL) begin
			for (int i = 0; i < 4; i++) begin
				if (idx_q == l4_base + 7'(i)) hdr_n.l4_ports[8*(3-i) +: 8] = in_b;
			end
		end
	end

	// report fields for the last word of the frame
	always_comb begin
		rep_n.tagged_res  = (hdr_n.ethertype == TPID) && (idx_q >= IDX_STRIP_END);
		rep_n.vlan_id     = rep_n.tagged_res ? {hdr_n.b14[3:0] & IHL_MASK, hdr_n.b15} : '0;
		if (hdr_n.ethertype[15:8] >= LEN_TYPE_MIN)
			rep_n.frame_kind = KIND_ETH2;
		else if (hdr_n.b14 == RAW_MARK && hdr_n.b15 == RAW_MARK)
			rep_n.frame_kind = KIND_RAW;
		else if (hdr_n.b14 == SNAP_MARK && hdr_n.b15 == SNAP_MARK && hdr_n.b16 == SNAP_CTRL)
			rep_n.frame_kind = KIND_SNAP;
		else
			rep_n.frame_kind = KIND_LLC;
		rep_n.ethertype   = hdr_n.ethertype;
		rep_n.dst_mac     = hdr_n.dst_mac;
		rep_n.src_mac     = hdr_n.src_mac;
		rep_n.ip_protocol = hdr_n.ip_protocol;
		rep_n.src_ip      = hdr_n.src_ip;
		rep_n.dst_ip      = hdr_n.dst_ip;
		rep_n.l4_ports    = hdr_n.l4_ports;
	end

	always_comb begin
		ent.pre     = held_q;
		ent.pre_cnt = '0;
		ent.data    = in_b;
		ent.last    = s_tlast;
		ent.rep     = s_tlast ? rep_n : '0;
		if (act == OP_INSERT && idx_q == IDX_TAG_END) begin
			ent.pre[0]  = TPID[15:8];
			ent.pre[1]  = TPID[7:0];
			ent.pre[2]  = tag_q[15:8];
			ent.pre[3]  = tag_q[7:0];
			ent.pre[4]  = held_q[0];
			ent.pre_cnt = CNT_W'(HOLD_MAX);
		end else if (act == OP_STRIP && in_strip_win) begin
			// short frame: flush what was held
			ent.pre_cnt = CNT_W'(idx_q - IDX_TYPE);
		end else if (act == OP_STRIP && idx_q == IDX_STRIP_END) begin
			ent.pre[0]  = held_q[HOLD_MAX-1];
			ent.pre_cnt = CNT_W'(1);
		end
	end

	assign push.valid = accept && !hold_now;
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			act_q <= OP_PASS;
			tag_q <= '0;
			hdr_q <= '0;
		end else if (accept) begin
			if (s_tlast)
				idx_q <= '0;
			else if (idx_q != IDX_MAX)
				idx_q <= idx_q + 7'd1;
			act_q <= act;
			if (first) tag_q <= in_tag;
			hdr_q <= hdr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !s_tlast) begin
			if (act == OP_INSERT && idx_q == IDX_TYPE) held_q[0] <= in_b;
			if (act == OP_STRIP) begin
				for (int i = 0; i < HOLD_MAX; i++) begin
					if (idx_q == IDX_TYPE + 7'(i)) held_q[i] <= in_b;
				end
			end
		end
	end

endmodule

@@ hdl/ehvr_queue.sv @@
// short entry queue between front and back end
// depends on ehvr_pkg
module ehvr_queue import ehvr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output logic   full,
	output logic   valid,
	output entry_t head
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push.valid && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (!push.valid && pop)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_q] <= push.entry;
	end

endmodule

@@ hdl/ehvr_back.sv @@
// back end: expands queue entries into output words, with output register
// depends on ehvr_pkg
module ehvr_back import ehvr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  entry_t                 q_head,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_byte[7:0], vlan_id[19:8], ethertype[35:20], dst_mac[83:36],
	// src_mac[131:84], ip_protocol[139:132], src_ip[171:140], dst_ip[203:172],
	// l4_ports[235:204], zero[239:236]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [2:0]             m_tuser,  // tagged_res[0], frame_kind[2:1]
	output logic                   m_tlast
);

	entry_t           cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] pos_q;
	logic             ovalid_q;
	logic             olast_q;
	logic [7:0]       obyte_q;
	rep_t             orep_q;

	logic out_free;
	logic cur_adv;
	logic at_end;
	logic cur_done;

	assign out_free = !ovalid_q || m_tready;
	assign cur_adv  = cur_valid_q && out_free;
	assign at_end   = (pos_q == cur_q.pre_cnt);
	assign cur_done = cur_adv && at_end;
	assign q_pop    = q_valid && (!cur_valid_q || cur_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			ovalid_q    <= 1'b0;
			olast_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (cur_adv) begin
				pos_q <= pos_q + CNT_W'(1);
			end
			if (cur_adv) begin
				ovalid_q <= 1'b1;
				olast_q  <= at_end && cur_q.last;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_head;
		if (cur_adv) begin
			obyte_q <= at_end ? cur_q.data : cur_q.pre[pos_q];
			orep_q  <= at_end ? cur_q.rep : '0;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tuser  = {orep_q.frame_kind, orep_q.tagged_res};
	assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, orep_q.l4_ports, orep_q.dst_ip,
		orep_q.src_ip, orep_q.ip_protocol, orep_q.src_mac, orep_q.dst_mac,
		orep_q.ethertype, orep_q.vlan_id, obyte_q};

endmodule

@@ hdl/ethernet_header_parse_vlan_retag_unit.sv @@
// top level of the ethernet header parse and vlan retag unit
// depends on ehvr_pkg, ehvr_front, ehvr_queue, ehvr_back
//
// usage
//   slave side takes one frame byte per word; tuser carries the opcode (pass,
//   insert tag, strip bytes 12 to 15) and tdata[23:8] the tag control word,
//   both sampled on the first byte of a frame; tlast marks the frame end
//   master side gives one rewritten byte per word; the word with tlast also
//   carries the header report of the input frame, all report bits are zero
//   on other words
// byte path
//   queue, then the current entry register, then the output register
// throughput
//   one byte per cycle while m_tready is high, set by the single output
//   register of the back end; an insert turns byte 13 into six output words,
//   so the frame gains four output words; a four entry queue between front
//   and back lets the front keep accepting while those words drain
// reset
//   arst_n clears the byte position, the queue and the output valid flag; the
//   first byte after reset starts a new frame
// stall
//   while m_tready is low the output word holds, the queue fills and then
//   s_tready drops until the queue has room again
module ethernet_header_parse_vlan_retag_unit import ehvr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // in_byte[7:0], new_tag[23:8]
	input  logic [1:0]             s_tuser,   // opcode[1:0]
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_byte[7:0], vlan_id[19:8], ethertype[35:20], dst_mac[83:36],
	// src_mac[131:84], ip_protocol[139:132], src_ip[171:140], dst_ip[203:172],
	// l4_ports[235:204], zero[239:236]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [2:0]             m_tuser,  // tagged_res[0], frame_kind[2:1]
	output logic                   m_tlast
);

	push_t  push;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	entry_t q_head;

	// parse, capture and classify
	ehvr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push)
	);

	// decouples the front from output stalls
	ehvr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.head   (q_head)
	);

	// expand entries into output words
	ehvr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// the front never pushes into a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_full)
		else $error("push into full queue");

	// the back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// report fields are zero except on the last word of a frame
	a_report_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == 3'b000 && m_tdata[235:8] == '0))
		else $error("report fields set on a word that is not last");

endmodule
